// File: sv/hmem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hi-res memory package
// Shared types, address constants and the display scanline decode for the
// hi-res memory block and its checker.
// ----------------------------------------------------------------------------
package hmem_pkg;

    localparam int unsigned AddrWidth = 16;
    localparam int unsigned DataWidth = 8;
    localparam int unsigned WordWidth = 16;
    localparam int unsigned LineWidth = 9;

    localparam logic [AddrWidth-1:0] SwPageRead = 16'hC01C;
    localparam logic [AddrWidth-1:0] SwPageOne  = 16'hC054;
    localparam logic [AddrWidth-1:0] SwPageTwo  = 16'hC055;
    localparam logic [AddrWidth-1:0] HiresLo    = 16'h2000;
    localparam logic [AddrWidth-1:0] HiresHi    = 16'h6000;
    localparam logic [AddrWidth-1:0] AddrLast   = 16'hFFFF;

    localparam logic [LineWidth-1:0] RowsPerPage = 9'd192;
    localparam logic [6:0]           BytesPerRow = 7'd40;
    localparam logic [LineWidth-1:0] MaxLine     = 9'd383;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_WORD  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_DONE
    } t_state;

    // Page flag after an access to address a.
    function automatic logic touch_switch(logic [AddrWidth-1:0] a, logic flag);
        logic f;
        f = flag;
        if (a == SwPageOne) begin
            f = 1'b0;
        end else if (a == SwPageTwo) begin
            f = 1'b1;
        end
        return f;
    endfunction

    function automatic logic in_hires(logic [AddrWidth-1:0] a);
        return (a >= HiresLo) && (a < HiresHi);
    endfunction

    // Invert the interleaved hi-res layout; screen holes give line 0.
    function automatic logic [LineWidth-1:0] scanline_of(logic [AddrWidth-1:0] a);
        logic [13:0]          o;
        logic [6:0]           rem;
        logic [1:0]           r_high;
        logic [LineWidth-1:0] line;
        o   = a[13:0] - HiresLo[13:0];
        rem = o[6:0];
        if (rem >= 7'(3 * BytesPerRow)) begin
            r_high = 2'd3;
        end else if (rem >= 7'(2 * BytesPerRow)) begin
            r_high = 2'd2;
        end else if (rem >= BytesPerRow) begin
            r_high = 2'd1;
        end else begin
            r_high = 2'd0;
        end
        line = {1'b0, r_high, 6'b0} + {3'b0, o[9:7], 3'b0} + {6'b0, o[12:10]}
             + (o[13] ? RowsPerPage : '0);
        if (r_high == 2'd3) begin
            line = '0;
        end
        return line;
    endfunction

endpackage

// File: sv/hires_memory_with_soft_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hi-res memory with page soft switch
// 64 KiB single-port byte RAM with byte read, byte write and little-endian
// word read, a page-two soft switch and display scanline dirty reporting.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       i_valid / o_ready  i_operation, i_address, i_write_data
//  out      o_valid / i_ready  o_read_data, o_dirty_valid, o_dirty_line
//
//  Byte writes and unused operations go straight to ST_DONE, byte reads
//  pass through ST_LO and word reads through ST_LO and ST_HI; the single RAM
//  port with its registered read data sets this, one byte access per cycle.
//  After reset a clearing pass zeroes the RAM, with o_ready low.
//  A finished result waits in the output register while the next beat is
//  taken; a second result waits in the block until the output is drained.
// ----------------------------------------------------------------------------
module hires_memory_with_soft_switch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_operation,
    input  logic [hmem_pkg::AddrWidth-1:0] i_address,
    input  logic [hmem_pkg::DataWidth-1:0] i_write_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hmem_pkg::WordWidth-1:0] o_read_data,
    output logic                           o_dirty_valid,
    output logic [hmem_pkg::LineWidth-1:0] o_dirty_line
);

    localparam int unsigned Depth = 2 ** hmem_pkg::AddrWidth;

    logic [hmem_pkg::DataWidth-1:0] ram [Depth];
    logic [hmem_pkg::DataWidth-1:0] r_q;

    hmem_pkg::t_state               r_state,  n_state;
    hmem_pkg::t_op                  r_op,     n_op;
    logic [hmem_pkg::AddrWidth-1:0] r_addr,   n_addr;
    logic [hmem_pkg::AddrWidth-1:0] r_clr,    n_clr;
    logic                           r_page2,  n_page2;
    logic [hmem_pkg::WordWidth-1:0] r_res_rd, n_res_rd;
    logic                           r_res_dv, n_res_dv;
    logic [hmem_pkg::LineWidth-1:0] r_res_dl, n_res_dl;

    logic                           r_out_valid;
    logic [hmem_pkg::WordWidth-1:0] r_out_rd;
    logic                           r_out_dv;
    logic [hmem_pkg::LineWidth-1:0] r_out_dl;

    logic                           mem_we;
    logic [hmem_pkg::AddrWidth-1:0] mem_addr;
    logic [hmem_pkg::DataWidth-1:0] mem_wdata;
    logic                           out_free;
    logic                           out_load;
    logic                           accept;
    logic [hmem_pkg::DataWidth-1:0] rd_byte;
    hmem_pkg::t_op                  in_op;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == hmem_pkg::ST_IDLE)
                   || ((r_state == hmem_pkg::ST_DONE) && out_free);
    assign accept   = i_valid && o_ready;
    assign in_op    = hmem_pkg::t_op'(i_operation);

    // Byte just read; the page flag stands in for RAM at its status address.
    assign rd_byte  = (r_addr == hmem_pkg::SwPageRead)
                    ? {{(hmem_pkg::DataWidth-1){1'b0}}, r_page2} : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmem_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_page2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_page2     <= n_page2;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_res_rd <= n_res_rd;
        r_res_dv <= n_res_dv;
        r_res_dl <= n_res_dl;
        if (out_load) begin
            r_out_rd <= r_res_rd;
            r_out_dv <= r_res_dv;
            r_out_dl <= r_res_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ram[mem_addr] <= mem_wdata;
        end
        r_q <= ram[mem_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_clr     = r_clr;
        n_page2   = r_page2;
        n_res_rd  = r_res_rd;
        n_res_dv  = r_res_dv;
        n_res_dl  = r_res_dl;
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = '0;
        out_load  = 1'b0;

        unique case (r_state)
            hmem_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == hmem_pkg::AddrLast) begin
                    n_state = hmem_pkg::ST_IDLE;
                end
            end
            hmem_pkg::ST_IDLE: begin
            end
            hmem_pkg::ST_LO: begin
                if (r_op == hmem_pkg::OP_WORD) begin
                    // Low byte in hand; issue the high byte with its own switch effect.
                    n_res_rd = {{hmem_pkg::DataWidth{1'b0}}, rd_byte};
                    n_addr   = r_addr + 1'b1;
                    mem_addr = n_addr;
                    n_page2  = hmem_pkg::touch_switch(n_addr, r_page2);
                    n_state  = hmem_pkg::ST_HI;
                end else begin
                    n_res_rd = {{hmem_pkg::DataWidth{1'b0}}, rd_byte};
                    n_state  = hmem_pkg::ST_DONE;
                end
            end
            hmem_pkg::ST_HI: begin
                n_res_rd = {rd_byte, r_res_rd[hmem_pkg::DataWidth-1:0]};
                n_state  = hmem_pkg::ST_DONE;
            end
            hmem_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = hmem_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hmem_pkg::ST_IDLE;
            end
        endcase

        if (accept) begin
            n_op     = in_op;
            n_addr   = i_address;
            mem_addr = i_address;
            n_res_rd = '0;
            n_res_dv = 1'b0;
            n_res_dl = '0;
            unique case (in_op) inside
                hmem_pkg::OP_READ, hmem_pkg::OP_WORD: begin
                    n_page2 = hmem_pkg::touch_switch(i_address, r_page2);
                    n_state = hmem_pkg::ST_LO;
                end
                hmem_pkg::OP_WRITE: begin
                    mem_we    = 1'b1;
                    mem_wdata = i_write_data;
                    if (hmem_pkg::in_hires(i_address)) begin
                        n_res_dv = 1'b1;
                        n_res_dl = hmem_pkg::scanline_of(i_address);
                    end else begin
                        n_page2 = hmem_pkg::touch_switch(i_address, r_page2);
                    end
                    n_state = hmem_pkg::ST_DONE;
                end
                hmem_pkg::OP_NONE: begin
                    n_state = hmem_pkg::ST_DONE;
                end
                default: begin
                    n_state = hmem_pkg::ST_DONE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_rd;
    assign o_dirty_valid = r_out_dv;
    assign o_dirty_line  = r_out_dl;

endmodule

// File: sv/hmem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hi-res memory port checker
// Watches the ports of the hi-res memory block for beat holds and result consistency.
// ----------------------------------------------------------------------------
module hmem_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic [1:0]                     i_operation,
    input logic [hmem_pkg::AddrWidth-1:0] i_address,
    input logic [hmem_pkg::DataWidth-1:0] i_write_data,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [hmem_pkg::WordWidth-1:0] o_read_data,
    input logic                           o_dirty_valid,
    input logic [hmem_pkg::LineWidth-1:0] o_dirty_line
);

    // Hold a waiting input beat.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_operation)
            && $stable(i_address) && $stable(i_write_data))
        else $error("input beat changed while waiting");

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data)
            && $stable(o_dirty_valid) && $stable(o_dirty_line))
        else $error("result beat changed while stalled");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_dirty_line <= hmem_pkg::MaxLine)
        else $error("dirty line out of range");

    // A dirty report only comes from a write, which reads nothing.
    a_dirty_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dirty_valid |-> o_read_data == '0)
        else $error("dirty write returned read data");

    a_clean_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dirty_valid |-> o_dirty_line == '0)
        else $error("line reported without dirty flag");

endmodule

bind hires_memory_with_soft_switch hmem_checker u_hmem_checker (.*);
